// File: rtl/assert_macros.svh
// Assertion macros used by the queue back end.
// Defining ASSERT_OFF removes every assertion from the build.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/tmsq_pkg.sv
package tmsq_pkg;

    // Default configuration of the queue.
    localparam int DEF_QUEUE_SLOTS = 8;
    localparam int DEF_PLAIN_BYTES = 6;
    localparam int DEF_CLOCK_BYTES = 15;
    localparam int DEF_TIMER_BYTES = 66;

    // Depth of the operation queue between front and back end.
    localparam int OP_FIFO_DEPTH = 2;

    // Command codes of an input word.
    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_POLL    = 2'd1,
        CMD_TX_DONE = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    // Message kinds.
    localparam logic [1:0] KIND_PLAIN = 2'd0;
    localparam logic [1:0] KIND_CLOCK = 2'd1;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ENQ_CMP,
        ST_ENQ_PLACE,
        ST_POLL_CMP
    } t_state;

    // Input word.
    typedef struct packed {
        logic [1:0]  command;
        logic [39:0] payload;
        logic [1:0]  kind;
        logic [3:0]  repeat_count;
        logic [15:0] delay_tenths;
        logic [31:0] now_tenths;
    } t_in_item;

    // Result word.
    typedef struct packed {
        logic        accepted;
        logic        send_valid;
        logic [39:0] send_payload;
        logic [1:0]  send_kind;
        logic [7:0]  word_count;
        logic [2:0]  occupancy;
    } t_out_item;

    // Classified operation handed from front to back end. For an enqueue
    // the time is the due time, otherwise it is the current time.
    typedef struct packed {
        t_cmd        cmd;
        logic [39:0] payload;
        logic [1:0]  kind;
        logic [3:0]  reps;
        logic [31:0] time_tenths;
    } t_op_word;

    // One queue slot as held in the RAM.
    typedef struct packed {
        logic [39:0] payload;
        logic [31:0] due;
        logic [1:0]  kind;
        logic [4:0]  repeats;
    } t_entry;

endpackage

// File: rtl/tmsq_ram.sv
module tmsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/tmsq_front.sv
module tmsq_front
    import tmsq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_in_item i_item,
    output logic     o_op_valid,
    output t_op_word o_op,
    input  logic     i_op_pop
);

    localparam int PW = (OP_FIFO_DEPTH > 1) ? $clog2(OP_FIFO_DEPTH) : 1;
    localparam int CW = $clog2(OP_FIFO_DEPTH + 1);

    t_op_word         r_slot [OP_FIFO_DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    t_op_word         w_op;
    logic             w_push;

    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
        if (p == PW'(OP_FIFO_DEPTH - 1)) begin
            return '0;
        end
        return p + PW'(1);
    endfunction

    // Classify the incoming word; an enqueue gets its due time here.
    always_comb begin
        w_op.cmd     = t_cmd'(i_item.command);
        w_op.payload = i_item.payload;
        w_op.kind    = i_item.kind;
        w_op.reps    = i_item.repeat_count;
        if (t_cmd'(i_item.command) == CMD_ENQUEUE) begin
            w_op.time_tenths = i_item.now_tenths + 32'(i_item.delay_tenths);
        end else begin
            w_op.time_tenths = i_item.now_tenths;
        end
    end

    assign busy       = (r_cnt == CW'(OP_FIFO_DEPTH));
    assign w_push     = start && !busy;
    assign o_op_valid = (r_cnt != '0);
    assign o_op       = r_slot[r_rd];

    // Queue pointers and fill count.
    always_comb begin
        n_wr  = w_push ? ptr_next(r_wr) : r_wr;
        n_rd  = i_op_pop ? ptr_next(r_rd) : r_rd;
        n_cnt = r_cnt + CW'(w_push) - CW'(i_op_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= w_op;
        end
    end

endmodule

// File: rtl/tmsq_back.sv
`include "assert_macros.svh"

module tmsq_back
    import tmsq_pkg::*;
#(
    parameter int QUEUE_SLOTS = DEF_QUEUE_SLOTS,
    parameter int PLAIN_BYTES = DEF_PLAIN_BYTES,
    parameter int CLOCK_BYTES = DEF_CLOCK_BYTES,
    parameter int TIMER_BYTES = DEF_TIMER_BYTES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_op_valid,
    input  t_op_word  i_op,
    output logic      o_op_pop,
    output logic      o_strobe,
    output t_out_item o_result
);

    localparam int IW = $clog2(QUEUE_SLOTS);
    localparam int CW = IW + 3;
    localparam logic [7:0] PlainWords = 8'(2 * PLAIN_BYTES);
    localparam logic [7:0] ClockWords = 8'(2 * CLOCK_BYTES);
    localparam logic [7:0] TimerWords = 8'(2 * TIMER_BYTES);

    t_state        r_state, n_state;
    logic [IW-1:0] r_head, n_head;
    logic [IW-1:0] r_tail, n_tail;
    logic [IW-1:0] r_pos, n_pos;
    logic          r_pending, n_pending;
    t_op_word      r_op, n_op;
    logic          r_strobe, n_strobe;
    t_out_item     r_result, n_result;

    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic [IW-1:0] w_raddr;
    t_entry        w_wdata;
    t_entry        w_rdata;
    logic [$bits(t_entry)-1:0] w_rdata_raw;

    function automatic logic [IW-1:0] slot_next(input logic [IW-1:0] a);
        if (a == IW'(QUEUE_SLOTS - 1)) begin
            return '0;
        end
        return a + IW'(1);
    endfunction

    function automatic logic [IW-1:0] slot_prev(input logic [IW-1:0] a);
        if (a == '0) begin
            return IW'(QUEUE_SLOTS - 1);
        end
        return a - IW'(1);
    endfunction

    function automatic logic [2:0] occ_of(input logic [IW-1:0] head,
                                          input logic [IW-1:0] tail);
        logic [IW:0]   diff;
        logic [CW-1:0] wide;
        if (tail >= head) begin
            diff = {1'b0, tail} - {1'b0, head};
        end else begin
            diff = {1'b0, tail} + (IW + 1)'(QUEUE_SLOTS) - {1'b0, head};
        end
        wide = CW'(diff);
        return wide[2:0];
    endfunction

    function automatic t_entry entry_of(input t_op_word op);
        t_entry e;
        e.payload = op.payload;
        e.due     = op.time_tenths;
        e.kind    = op.kind;
        e.repeats = {1'b0, op.reps};
        return e;
    endfunction

    function automatic logic [7:0] words_of(input logic [1:0] kind);
        if (kind == KIND_PLAIN) begin
            return PlainWords;
        end
        if (kind == KIND_CLOCK) begin
            return ClockWords;
        end
        return TimerWords;
    endfunction

    // Slot storage.
    tmsq_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (QUEUE_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_raw)
    );

    assign w_rdata = t_entry'(w_rdata_raw);

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_op_valid) begin
                    case (i_op.cmd)
                        CMD_ENQUEUE: begin
                            if (slot_next(r_tail) != r_head && r_tail != r_head) begin
                                n_state = ST_ENQ_CMP;
                            end
                        end
                        CMD_POLL: begin
                            if (!r_pending && r_head != r_tail) begin
                                n_state = ST_POLL_CMP;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ENQ_CMP: begin
                if (r_op.time_tenths >= w_rdata.due) begin
                    n_state = ST_IDLE;
                end else if (slot_prev(r_pos) == r_head) begin
                    n_state = ST_ENQ_PLACE;
                end
            end
            ST_ENQ_PLACE: n_state = ST_IDLE;
            ST_POLL_CMP:  n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // Datapath, RAM accesses and result of the sequencer.
    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_pos     = r_pos;
        n_pending = r_pending;
        n_op      = r_op;
        n_strobe  = 1'b0;
        n_result  = '0;
        o_op_pop  = 1'b0;
        w_we      = 1'b0;
        w_waddr   = r_pos;
        w_wdata   = entry_of(r_op);
        w_raddr   = slot_prev(r_pos);
        case (r_state)
            ST_IDLE: begin
                if (i_op_valid) begin
                    o_op_pop = 1'b1;
                    n_op     = i_op;
                    case (i_op.cmd)
                        CMD_ENQUEUE: begin
                            if (slot_next(r_tail) == r_head) begin
                                // Ring full: the message is dropped.
                                n_strobe = 1'b1;
                            end else begin
                                n_tail  = slot_next(r_tail);
                                n_pos   = r_tail;
                                w_raddr = slot_prev(r_tail);
                                if (r_tail == r_head) begin
                                    // Empty ring: place straight at the tail.
                                    w_we              = 1'b1;
                                    w_waddr           = r_tail;
                                    w_wdata           = entry_of(i_op);
                                    n_strobe          = 1'b1;
                                    n_result.accepted = 1'b1;
                                end
                            end
                        end
                        CMD_POLL: begin
                            w_raddr = r_head;
                            if (r_pending || r_head == r_tail) begin
                                n_strobe = 1'b1;
                            end
                        end
                        CMD_TX_DONE: begin
                            n_pending = 1'b0;
                            n_strobe  = 1'b1;
                        end
                        default: n_strobe = 1'b1;
                    endcase
                end
            end
            ST_ENQ_CMP: begin
                w_we = 1'b1;
                if (r_op.time_tenths >= w_rdata.due) begin
                    n_strobe          = 1'b1;
                    n_result.accepted = 1'b1;
                end else begin
                    // Move the later entry up one slot and look further down.
                    w_wdata = w_rdata;
                    n_pos   = slot_prev(r_pos);
                    w_raddr = slot_prev(slot_prev(r_pos));
                end
            end
            ST_ENQ_PLACE: begin
                w_we              = 1'b1;
                n_strobe          = 1'b1;
                n_result.accepted = 1'b1;
            end
            ST_POLL_CMP: begin
                n_strobe = 1'b1;
                if (w_rdata.due <= r_op.time_tenths) begin
                    n_result.send_valid   = 1'b1;
                    n_result.send_payload = w_rdata.payload;
                    n_result.send_kind    = w_rdata.kind;
                    n_result.word_count   = words_of(w_rdata.kind);
                    n_pending             = 1'b1;
                    if (w_rdata.repeats == '0) begin
                        n_head = slot_next(r_head);
                    end else begin
                        w_we            = 1'b1;
                        w_waddr         = r_head;
                        w_wdata         = w_rdata;
                        w_wdata.repeats = w_rdata.repeats - 5'd1;
                    end
                end
            end
            default: n_strobe = 1'b0;
        endcase
        n_result.occupancy = occ_of(n_head, n_tail);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_pending <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_pending <= n_pending;
            r_strobe  <= n_strobe;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_op     <= n_op;
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // A send always sets the pending mark, which was clear before.
    `ASSERT_IMPL(a_send_sets_pending, i_clk, i_rst_n, r_strobe && r_result.send_valid, r_pending && !$past(r_pending))
    // The shifting walk never reaches the head slot.
    `ASSERT_IMPL(a_walk_above_head, i_clk, i_rst_n, r_state == ST_ENQ_CMP, r_pos != r_head)
    // A head check is only made on a non-empty ring with no send pending.
    `ASSERT_IMPL(a_poll_guarded, i_clk, i_rst_n, r_state == ST_POLL_CMP, r_head != r_tail && !r_pending)
    // Placing at the bottom of the walk completes the enqueue.
    `ASSERT_NEXT(a_place_reports, i_clk, i_rst_n, r_state == ST_ENQ_PLACE, r_strobe && r_result.accepted && r_state == ST_IDLE)

endmodule

// File: rtl/timed_message_send_queue_core.sv
// Channel   Direction  Handshake                    Word
// command   in         start high, busy low         i_item  (t_in_item)
// result    out        o_strobe high for one cycle  o_result (t_out_item)
//
// Each word gives one result. Transmit-done, ignored commands, refused enqueues, enqueues
// into an empty ring and polls that meet a pending send or an empty ring are answered from
// the idle state; a poll that checks the head passes the head-compare state, and any
// other enqueue walks, moving k entries up one slot per cycle in the two-port slot RAM.
// Busy rises only while the two-word queue behind the front end is full.
// Reset clears the ring pointers and pending mark, not the RAM; the receiver never stalls.
module timed_message_send_queue_core
    import tmsq_pkg::*;
#(
    parameter int QUEUE_SLOTS = DEF_QUEUE_SLOTS,
    parameter int PLAIN_BYTES = DEF_PLAIN_BYTES,
    parameter int CLOCK_BYTES = DEF_CLOCK_BYTES,
    parameter int TIMER_BYTES = DEF_TIMER_BYTES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_strobe,
    output t_out_item o_result
);

    logic     w_op_valid;
    logic     w_op_pop;
    t_op_word w_op;

    // Front end: accepts and classifies command words.
    tmsq_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_op_valid (w_op_valid),
        .o_op       (w_op),
        .i_op_pop   (w_op_pop)
    );

    // Back end: keeps the sorted ring and produces results.
    tmsq_back #(
        .QUEUE_SLOTS (QUEUE_SLOTS),
        .PLAIN_BYTES (PLAIN_BYTES),
        .CLOCK_BYTES (CLOCK_BYTES),
        .TIMER_BYTES (TIMER_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (w_op_valid),
        .i_op       (w_op),
        .o_op_pop   (w_op_pop),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

endmodule
